/* rtl/sqdbs_pkg.sv */
// ----------------------------------------------------------------------------
// sqdbs_pkg: shared types and constants
// Field widths, token codes and status groups for the squared-difference
// horizontal box sum.
// ----------------------------------------------------------------------------
package sqdbs_pkg;

    localparam int SQDBS_SAMPLE_BITS = 16;
    localparam int SQDBS_MAX_RADIUS  = 8;
    localparam int SQDBS_MAX_OFFSET  = 8;

    localparam int FIELD_BITS    = 16;
    localparam int S_TDATA_BITS  = 32;
    localparam int SUM_BITS      = 38;
    localparam int M_TDATA_BITS  = 40;
    localparam int OFFCFG_BITS   = 5;
    localparam int RADCFG_BITS   = 4;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int FILL_BITS     = 6;

    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_DIST = 2'd1;
    localparam kind_t KIND_DUP  = 2'd2;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  last;
    } tok_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic drop;
    } box_stat_t;

endpackage

/* rtl/sqdbs_cell.sv */
// ----------------------------------------------------------------------------
// sqdbs_cell: one tap of a shift chain
// Takes its neighbor's value on a shift, or a common value on a broadcast.
// ----------------------------------------------------------------------------
module sqdbs_cell #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic             load,
    input  logic [WIDTH-1:0] prev,
    input  logic [WIDTH-1:0] bcast,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= load ? bcast : prev;
        end
    end

    assign q = q_reg;

endmodule

/* rtl/sqdbs_sq3.sv */
// ----------------------------------------------------------------------------
// sqdbs_sq3: tripled squared difference pipeline
// Four stages: operand register, absolute difference, square, times three.
// ----------------------------------------------------------------------------
module sqdbs_sq3 import sqdbs_pkg::*; #(
    parameter int SAMPLE_BITS = SQDBS_SAMPLE_BITS,
    parameter int RAD_BITS    = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tok_t                       in_tok,
    input  logic [RAD_BITS-1:0]        in_rad,
    input  logic [SAMPLE_BITS-1:0]     in_c,
    input  logic [SAMPLE_BITS-1:0]     in_n,
    output tok_t                       out_tok,
    output logic [RAD_BITS-1:0]        out_rad,
    output logic [2*SAMPLE_BITS+1:0]   out_d
);

    localparam int DIST_BITS = 2 * SAMPLE_BITS + 2;

    tok_t                     tok_reg [4];
    logic [RAD_BITS-1:0]      rad_reg [4];
    logic [SAMPLE_BITS-1:0]   c_reg;
    logic [SAMPLE_BITS-1:0]   n_reg;
    logic [SAMPLE_BITS-1:0]   diff_reg;
    logic [2*SAMPLE_BITS-1:0] sq_reg;
    logic [DIST_BITS-1:0]     d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                tok_reg[i] <= '0;
            end
        end
        else
        begin
            tok_reg[0] <= in_tok;
            for (int i = 1; i < 4; i++)
            begin
                tok_reg[i] <= tok_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0] <= in_rad;
        for (int i = 1; i < 4; i++)
        begin
            rad_reg[i] <= rad_reg[i-1];
        end
        c_reg    <= in_c;
        n_reg    <= in_n;
        diff_reg <= (c_reg > n_reg) ? (c_reg - n_reg) : (n_reg - c_reg);
        sq_reg   <= diff_reg * diff_reg;
        d_reg    <= {1'b0, sq_reg, 1'b0} + {2'b00, sq_reg};
    end

    assign out_tok = tok_reg[3];
    assign out_rad = rad_reg[3];
    assign out_d   = d_reg;

endmodule

/* rtl/sqdbs_box.sv */
// ----------------------------------------------------------------------------
// sqdbs_box: running box sum over a chain of distance cells
// Broadcast the first distance of a row into every cell, then shift one
// value per step and keep the window total as a running sum.
// ----------------------------------------------------------------------------
module sqdbs_box import sqdbs_pkg::*; #(
    parameter int MAX_RADIUS = SQDBS_MAX_RADIUS,
    parameter int RAD_BITS   = 4,
    parameter int DIST_BITS  = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tok_t                 in_tok,
    input  logic [RAD_BITS-1:0]  in_rad,
    input  logic [DIST_BITS-1:0] in_d,
    output box_stat_t            stat,
    output logic [SUM_BITS-1:0]  res_sum
);

    localparam int DWIN      = 2 * MAX_RADIUS + 1;
    localparam int WIDX_BITS = $clog2(DWIN);
    localparam int CNT_BITS  = $clog2(MAX_RADIUS + 2);

    logic [DIST_BITS-1:0]       cell_q    [DWIN];
    logic [DIST_BITS-1:0]       cell_prev [DWIN];
    logic [CNT_BITS-1:0]        s_reg;
    logic [CNT_BITS-1:0]        s_next;
    logic [CNT_BITS-1:0]        s_inc;
    logic [SUM_BITS-1:0]        sum_reg;
    logic [SUM_BITS-1:0]        sum_next;
    logic [SUM_BITS-1:0]        prod_sum;
    logic [RAD_BITS:0]          span;
    logic [DIST_BITS+RAD_BITS:0] prod;
    logic [DIST_BITS-1:0]       v;
    logic [DIST_BITS-1:0]       tail;
    logic                       step;
    logic                       first;
    logic                       emit;

    always_comb
    begin
        step     = in_tok.valid && (in_tok.kind != KIND_NONE);
        first    = step && (in_tok.kind == KIND_DIST) && (s_reg == '0);
        v        = (in_tok.kind == KIND_DUP) ? cell_q[0] : in_d;
        tail     = cell_q[WIDX_BITS'({in_rad, 1'b0})];
        span     = {in_rad, 1'b0} + 1'b1;
        prod     = in_d * span;
        prod_sum = SUM_BITS'(prod);
        sum_next = first ? prod_sum : (sum_reg + SUM_BITS'(v) - SUM_BITS'(tail));
        s_inc    = (&s_reg) ? s_reg : (s_reg + 1'b1);
        emit     = step && (s_inc > CNT_BITS'(in_rad));
        s_next   = s_reg;
        if (step)
        begin
            s_next = in_tok.last ? '0 : s_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
        end
        else
        begin
            s_reg <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sum_reg <= sum_next;
        end
    end

    for (genvar i = 0; i < DWIN; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_prev[i] = v;
        end
        else
        begin : g_body
            assign cell_prev[i] = cell_q[i-1];
        end
        sqdbs_cell #(
            .WIDTH (DIST_BITS)
        ) u_cell (
            .clk   (clk),
            .en    (step),
            .load  (first),
            .prev  (cell_prev[i]),
            .bcast (in_d),
            .q     (cell_q[i])
        );
    end

    assign stat.valid = emit;
    assign stat.last  = in_tok.last;
    assign stat.drop  = in_tok.valid && !emit;
    assign res_sum    = sum_next;

endmodule

/* rtl/sq_diff_horizontal_box_sum_top.sv */
// ----------------------------------------------------------------------------
// sq_diff_horizontal_box_sum_top: patch distance box sum for one image row
// Tripled squared difference of center and shifted neighbor samples, summed
// over a horizontal window with edge replication.
// ----------------------------------------------------------------------------
// One column is taken per cycle while the row streams in. After the item
// marked with tlast the block spends min(lag, row width) + radius further
// steps (lag is the positive part of offset_x, at most MAX_OFFSET + MAX_RADIUS
// steps) issuing the right-edge distances and window shifts, one per cycle
// through the single square unit and the distance cell chain while the output
// keeps up; s_axis_tready is low meanwhile, and also whenever eight requests
// are outstanding. A result passes through the square pipeline and the box
// sum and then waits in an eight-entry output queue. Offset and radius are
// sampled at the first column of each row.
module sq_diff_horizontal_box_sum_top import sqdbs_pkg::*; #(
    parameter int SAMPLE_BITS = SQDBS_SAMPLE_BITS,
    parameter int MAX_RADIUS  = SQDBS_MAX_RADIUS,
    parameter int MAX_OFFSET  = SQDBS_MAX_OFFSET
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // s_axis_tdata: [15:0] center_sample, [31:16] neighbor_sample
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [S_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                     s_axis_tlast,
    // m_axis_tdata: [37:0] distance_sum, [39:38] zero
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [M_TDATA_BITS-1:0]  m_axis_tdata,
    output logic                     m_axis_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int LAG_BITS  = $clog2(MAX_OFFSET + 1);
    localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
    localparam int CIDX_BITS = (MAX_OFFSET > 1) ? $clog2(MAX_OFFSET) : 1;
    localparam int DIST_BITS = 2 * SAMPLE_BITS + 2;
    localparam logic [FILL_BITS-1:0] FILL_CAP = '1;
    localparam logic REG_OFFSET_X   = 1'b0;
    localparam logic REG_BOX_RADIUS = 1'b1;

    logic [OFFCFG_BITS-1:0] cfg_off_reg;
    logic [RADCFG_BITS-1:0] cfg_rad_reg;
    logic                   cfg_wr;

    logic [FILL_BITS-1:0]   fill_reg, fill_next, fill_inc;
    logic [LAG_BITS-1:0]    row_mag_reg, row_mag_next;
    logic                   row_neg_reg, row_neg_next;
    logic [RAD_BITS-1:0]    row_rad_reg, row_rad_next;
    logic                   flush_reg, flush_next;
    logic [LAG_BITS-1:0]    fcnt_reg, fcnt_next;
    logic [RAD_BITS-1:0]    dcnt_reg, dcnt_next;
    logic [FCNT_BITS-1:0]   pend_reg, pend_next;

    logic [OFFCFG_BITS-1:0] mag_raw;
    logic [LAG_BITS-1:0]    mag_eff, cur_mag, cur_lag, b_sel, pend_d;
    logic [RAD_BITS-1:0]    rad_eff, cur_rad;
    logic                   cur_neg, first, has_d;
    logic                   credit, acc, fstep, issue, pop;

    logic [SAMPLE_BITS-1:0] in_c, in_n, op_c, op_n;
    logic [SAMPLE_BITS-1:0] cchain_q [MAX_OFFSET];
    logic [SAMPLE_BITS-1:0] nchain_q [MAX_OFFSET];
    logic [SAMPLE_BITS-1:0] cprev    [MAX_OFFSET];
    logic [SAMPLE_BITS-1:0] nprev    [MAX_OFFSET];
    logic                   c_use_in, n_use_in;
    logic [CIDX_BITS-1:0]   c_idx, n_idx;
    tok_t                   tok;

    tok_t                   d_tok;
    logic [RAD_BITS-1:0]    d_rad;
    logic [DIST_BITS-1:0]   d_val;
    box_stat_t              stat;
    logic [SUM_BITS-1:0]    res_sum;

    logic [SUM_BITS:0]      fifo_reg [FIFO_DEPTH];
    logic [FPTR_BITS-1:0]   wptr_reg, rptr_reg;
    logic [FCNT_BITS-1:0]   fcount_reg, fcount_next;
    logic [SUM_BITS:0]      head;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_off_reg <= '0;
            cfg_rad_reg <= RADCFG_BITS'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_OFFSET_X:   cfg_off_reg <= pwdata[OFFCFG_BITS-1:0];
                REG_BOX_RADIUS: cfg_rad_reg <= pwdata[RADCFG_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_OFFSET_X:   prdata = {{(APB_DATA_BITS-OFFCFG_BITS){1'b0}}, cfg_off_reg};
            REG_BOX_RADIUS: prdata = {{(APB_DATA_BITS-RADCFG_BITS){1'b0}}, cfg_rad_reg};
            default:        prdata = '0;
        endcase
    end

    // clamp the configured offset and radius
    assign mag_raw = cfg_off_reg[OFFCFG_BITS-1] ? (~cfg_off_reg + 1'b1) : cfg_off_reg;
    assign mag_eff = ({1'b0, mag_raw} > (OFFCFG_BITS+1)'(MAX_OFFSET)) ?
                     LAG_BITS'(MAX_OFFSET) : LAG_BITS'(mag_raw);
    assign rad_eff = ({1'b0, cfg_rad_reg} > (RADCFG_BITS+1)'(MAX_RADIUS)) ?
                     RAD_BITS'(MAX_RADIUS) : RAD_BITS'(cfg_rad_reg);

    assign in_c = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_n = s_axis_tdata[FIELD_BITS +: SAMPLE_BITS];

    assign credit        = pend_reg < FCNT_BITS'(FIFO_DEPTH);
    assign s_axis_tready = !flush_reg && credit;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign fstep         = flush_reg && credit;
    assign issue         = acc || fstep;

    // issue sequencer: one column or one flush step per cycle while fewer than eight requests are outstanding
    always_comb
    begin
        first    = (fill_reg == '0);
        cur_mag  = first ? mag_eff : row_mag_reg;
        cur_neg  = first ? cfg_off_reg[OFFCFG_BITS-1] : row_neg_reg;
        cur_rad  = first ? rad_eff : row_rad_reg;
        cur_lag  = cur_neg ? '0 : cur_mag;
        fill_inc = (fill_reg == FILL_CAP) ? fill_reg : (fill_reg + 1'b1);
        has_d    = cur_neg || (fill_reg >= FILL_BITS'(cur_lag));
        b_sel    = (FILL_BITS'(cur_mag) > fill_reg) ? LAG_BITS'(fill_reg) : cur_mag;
        pend_d   = (FILL_BITS'(cur_lag) < fill_inc) ? cur_lag : LAG_BITS'(fill_inc);

        fill_next    = fill_reg;
        row_mag_next = row_mag_reg;
        row_neg_next = row_neg_reg;
        row_rad_next = row_rad_reg;
        flush_next   = flush_reg;
        fcnt_next    = fcnt_reg;
        dcnt_next    = dcnt_reg;
        tok          = '0;
        c_use_in     = 1'b1;
        n_use_in     = 1'b1;
        c_idx        = '0;
        n_idx        = '0;

        if (acc)
        begin
            tok.valid = 1'b1;
            tok.kind  = has_d ? KIND_DIST : KIND_NONE;
            tok.last  = s_axis_tlast && (pend_d == '0) && (cur_rad == '0);
            if (cur_neg)
            begin
                if (b_sel != '0)
                begin
                    n_use_in = 1'b0;
                    n_idx    = CIDX_BITS'(b_sel - 1'b1);
                end
            end
            else if (cur_lag != '0)
            begin
                c_use_in = 1'b0;
                c_idx    = CIDX_BITS'(cur_lag - 1'b1);
            end
            if (first)
            begin
                row_mag_next = cur_mag;
                row_neg_next = cur_neg;
                row_rad_next = cur_rad;
            end
            if (s_axis_tlast)
            begin
                fill_next  = '0;
                flush_next = (pend_d != '0) || (cur_rad != '0);
                fcnt_next  = pend_d;
                dcnt_next  = cur_rad;
            end
            else
            begin
                fill_next = fill_inc;
            end
        end
        else if (fstep)
        begin
            tok.valid = 1'b1;
            if (fcnt_reg != '0)
            begin
                tok.kind  = KIND_DIST;
                tok.last  = (fcnt_reg == LAG_BITS'(1)) && (dcnt_reg == '0);
                c_use_in  = 1'b0;
                n_use_in  = 1'b0;
                c_idx     = CIDX_BITS'(fcnt_reg - 1'b1);
                fcnt_next = fcnt_reg - 1'b1;
            end
            else
            begin
                tok.kind  = KIND_DUP;
                tok.last  = (dcnt_reg == RAD_BITS'(1));
                dcnt_next = dcnt_reg - 1'b1;
            end
            if (tok.last)
            begin
                flush_next = 1'b0;
            end
        end
    end

    assign op_c = c_use_in ? in_c : cchain_q[c_idx];
    assign op_n = n_use_in ? in_n : nchain_q[n_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            row_mag_reg <= '0;
            row_neg_reg <= 1'b0;
            row_rad_reg <= '0;
            flush_reg   <= 1'b0;
            fcnt_reg    <= '0;
            dcnt_reg    <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            row_mag_reg <= row_mag_next;
            row_neg_reg <= row_neg_next;
            row_rad_reg <= row_rad_next;
            flush_reg   <= flush_next;
            fcnt_reg    <= fcnt_next;
            dcnt_reg    <= dcnt_next;
            pend_reg    <= pend_next;
        end
    end

    assign pend_next = pend_reg + FCNT_BITS'(issue) - FCNT_BITS'(pop)
                       - FCNT_BITS'(stat.drop);

    // sample delay chains
    for (genvar i = 0; i < MAX_OFFSET; i++)
    begin : g_tap
        if (i == 0)
        begin : g_head
            assign cprev[i] = in_c;
            assign nprev[i] = in_n;
        end
        else
        begin : g_body
            assign cprev[i] = cchain_q[i-1];
            assign nprev[i] = nchain_q[i-1];
        end
        sqdbs_cell #(
            .WIDTH (SAMPLE_BITS)
        ) u_center (
            .clk   (clk),
            .en    (acc),
            .load  (1'b0),
            .prev  (cprev[i]),
            .bcast ('0),
            .q     (cchain_q[i])
        );
        sqdbs_cell #(
            .WIDTH (SAMPLE_BITS)
        ) u_neighbor (
            .clk   (clk),
            .en    (acc),
            .load  (1'b0),
            .prev  (nprev[i]),
            .bcast ('0),
            .q     (nchain_q[i])
        );
    end

    sqdbs_sq3 #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RAD_BITS    (RAD_BITS)
    ) u_sq3 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tok  (tok),
        .in_rad  (fstep ? row_rad_reg : cur_rad),
        .in_c    (op_c),
        .in_n    (op_n),
        .out_tok (d_tok),
        .out_rad (d_rad),
        .out_d   (d_val)
    );

    sqdbs_box #(
        .MAX_RADIUS (MAX_RADIUS),
        .RAD_BITS   (RAD_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_box (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tok  (d_tok),
        .in_rad  (d_rad),
        .in_d    (d_val),
        .stat    (stat),
        .res_sum (res_sum)
    );

    // output queue
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = fifo_reg[rptr_reg];
    assign fcount_next = fcount_reg + FCNT_BITS'(stat.valid) - FCNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (stat.valid)
        begin
            fifo_reg[wptr_reg] <= {stat.last, res_sum};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            fcount_reg <= '0;
        end
        else
        begin
            if (stat.valid)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            fcount_reg <= fcount_next;
        end
    end

    assign m_axis_tvalid = (fcount_reg != '0);
    assign m_axis_tdata  = {{(M_TDATA_BITS-SUM_BITS){1'b0}}, head[SUM_BITS-1:0]};
    assign m_axis_tlast  = head[SUM_BITS];

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.valid |-> (fcount_reg != FCNT_BITS'(FIFO_DEPTH)))
        else $error("result written into a full output queue");

    a_credit_cover: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg >= fcount_reg)
        else $error("outstanding request count below queue fill");

    a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tlast && (cur_rad != '0)) |=> flush_reg)
        else $error("row end with nonzero radius did not start a flush");

endmodule

/* tb/box_sum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_sum_checker: result checker for the squared-difference box sum
// Watches the column and result streams and the register port. It keeps its
// own copy of the row state, works out the box sums that each accepted column
// completes, and compares every result against the oldest expected sum.
// ----------------------------------------------------------------------------
module box_sum_checker import sqdbs_pkg::*; #(
    parameter logic [APB_ADDR_BITS-1:0] OFFSET_ADDR = '0,
    parameter logic [APB_ADDR_BITS-1:0] RADIUS_ADDR = '0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [S_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                     s_axis_tlast,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [M_TDATA_BITS-1:0]  m_axis_tdata,
    input  logic                     m_axis_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic [APB_DATA_BITS-1:0] prdata,
    input  logic                     pready,
    output int                       errors,
    output int                       pending,
    output int                       columns_in,
    output int                       rows_in,
    output int                       sums_out
);

    localparam int NB_DEPTH = SQDBS_MAX_OFFSET + 1;
    localparam int D_DEPTH  = 2 * SQDBS_MAX_RADIUS + 1;
    localparam int FILL_MAX = 63;

    typedef struct {
        logic [SUM_BITS-1:0] sum;
        logic                done;
    } box_result_t;

    box_result_t expected_sums[$];

    logic [OFFCFG_BITS-1:0] offset_reg;
    logic [RADCFG_BITS-1:0] radius_reg;
    logic [15:0]            nb_hist [NB_DEPTH];
    logic [15:0]            c_hist [NB_DEPTH];
    logic [33:0]            d_hist [D_DEPTH];
    int                     cols_seen;
    int                     d_seen;
    int                     row_shift;
    int                     row_half;

    initial
    begin
        errors     = 0;
        pending    = 0;
        columns_in = 0;
        rows_in    = 0;
        sums_out   = 0;
    end

    function automatic logic [33:0] tri_sq(logic [15:0] a, logic [15:0] b);
        logic [16:0] diff;
        logic [33:0] sq;
        diff = (a > b) ? a - b : b - a;
        sq = diff * diff;
        return sq * 34'd3;
    endfunction

    function automatic logic [SUM_BITS-1:0] window_sum(int m);
        int                  cap;
        int                  b;
        logic [SUM_BITS-1:0] acc;
        cap = d_seen - 1;
        acc = '0;
        for (int j = -row_half; j <= row_half; j++)
        begin
            b = m - j;
            if (b < 0)
                b = 0;
            if (b > cap)
                b = cap;
            if (b >= 0 && b < D_DEPTH)
                acc += d_hist[b];
        end
        return acc;
    endfunction

    function automatic void expect_sum(logic [SUM_BITS-1:0] sum, logic done);
        expected_sums.push_back('{sum, done});
    endfunction

    function automatic void post_distance(logic [33:0] d);
        for (int i = D_DEPTH - 1; i > 0; i--)
            d_hist[i] = d_hist[i-1];
        d_hist[0] = d;
        if (d_seen < FILL_MAX)
            d_seen++;
        if (d_seen > row_half)
            expect_sum(window_sum(row_half), 1'b0);
    endfunction

    function automatic void predict_column(logic [15:0] c, logic [15:0] nb, logic is_last);
        int          raw;
        int          lag;
        int          t;
        int          k;
        int          b;
        int          flush_n;
        int          top;
        int          base;
        box_result_t tail;
        base = expected_sums.size();
        if (cols_seen == 0)
        begin
            raw = $signed(offset_reg);
            if (raw > SQDBS_MAX_OFFSET)
                raw = SQDBS_MAX_OFFSET;
            if (raw < -SQDBS_MAX_OFFSET)
                raw = -SQDBS_MAX_OFFSET;
            row_shift = raw;
            row_half  = (radius_reg > SQDBS_MAX_RADIUS) ? SQDBS_MAX_RADIUS : int'(radius_reg);
        end
        t = cols_seen;
        for (int i = NB_DEPTH - 1; i > 0; i--)
        begin
            nb_hist[i] = nb_hist[i-1];
            c_hist[i]  = c_hist[i-1];
        end
        nb_hist[0] = nb;
        c_hist[0]  = c;
        if (cols_seen < FILL_MAX)
            cols_seen++;

        lag = (row_shift > 0) ? row_shift : 0;
        if (row_shift >= 0)
        begin
            if (t >= lag)
                post_distance(tri_sq(c_hist[lag], nb_hist[0]));
        end
        else
        begin
            k = -row_shift;
            b = (k < t) ? k : t;
            post_distance(tri_sq(c_hist[0], nb_hist[b]));
        end

        if (is_last)
        begin
            flush_n = (lag < cols_seen) ? lag : cols_seen;
            for (int i = 0; i < flush_n; i++)
                post_distance(tri_sq(c_hist[flush_n-1-i], nb_hist[0]));
            if (row_half == 0)
            begin
                if (expected_sums.size() > base)
                begin
                    tail = expected_sums.pop_back();
                    tail.done = 1'b1;
                    expected_sums.push_back(tail);
                end
            end
            else
            begin
                top = row_half - 1;
                if (d_seen > 0 && top > d_seen - 1)
                    top = d_seen - 1;
                for (int m = top; m >= 0; m--)
                    expect_sum(window_sum(m), m == 0);
            end
            cols_seen = 0;
            d_seen    = 0;
            rows_in++;
        end
    endfunction

    always @(posedge clk)
    begin
        box_result_t want;
        if (!rst_n)
        begin
            offset_reg = '0;
            radius_reg = RADCFG_BITS'(1);
            for (int i = 0; i < NB_DEPTH; i++)
            begin
                nb_hist[i] = '0;
                c_hist[i]  = '0;
            end
            for (int i = 0; i < D_DEPTH; i++)
                d_hist[i] = '0;
            cols_seen = 0;
            d_seen    = 0;
            row_shift = 0;
            row_half  = 0;
            expected_sums.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == OFFSET_ADDR)
                        offset_reg = pwdata[OFFCFG_BITS-1:0];
                    else if (paddr == RADIUS_ADDR)
                        radius_reg = pwdata[RADCFG_BITS-1:0];
                end
                else if (paddr == OFFSET_ADDR && prdata[OFFCFG_BITS-1:0] !== offset_reg)
                begin
                    errors++;
                    $display("%0t: offset_x read expected %0d got %0d", $time,
                             offset_reg, prdata[OFFCFG_BITS-1:0]);
                end
                else if (paddr == RADIUS_ADDR && prdata[RADCFG_BITS-1:0] !== radius_reg)
                begin
                    errors++;
                    $display("%0t: box_radius read expected %0d got %0d", $time,
                             radius_reg, prdata[RADCFG_BITS-1:0]);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                columns_in++;
                predict_column(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                sums_out++;
                if (expected_sums.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none got sum %0d last %0b",
                             $time, m_axis_tdata[SUM_BITS-1:0], m_axis_tlast);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (m_axis_tdata[SUM_BITS-1:0] !== want.sum)
                    begin
                        errors++;
                        $display("%0t: distance_sum expected %0d got %0d", $time,
                                 want.sum, m_axis_tdata[SUM_BITS-1:0]);
                    end
                    if (m_axis_tlast !== want.done)
                    begin
                        errors++;
                        $display("%0t: row_done expected %0b got %0b", $time,
                                 want.done, m_axis_tlast);
                    end
                    if (m_axis_tdata[M_TDATA_BITS-1:SUM_BITS] !== '0)
                    begin
                        errors++;
                        $display("%0t: tdata padding expected 0 got %0h", $time,
                                 m_axis_tdata[M_TDATA_BITS-1:SUM_BITS]);
                    end
                end
            end
        end
        pending = expected_sums.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for sq_diff_horizontal_box_sum_top
// Streams image rows of varied widths and sample mixes through the block
// under many offset and radius settings, including clamped values, short rows
// and a setting changed mid-row, with random gaps and stalls on both streams.
// Results are checked by box_sum_checker.
// ----------------------------------------------------------------------------
module testbench;
    import sqdbs_pkg::*;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_OFFSET_X   = 3'd0;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_BOX_RADIUS = 3'd4;
    localparam int FLUSH_WAIT   = SQDBS_MAX_OFFSET + SQDBS_MAX_RADIUS + 16;
    localparam int RANDOM_ITEMS = 380;

    localparam int MIX_RANDOM  = 0;
    localparam int MIX_EXTREME = 1;
    localparam int MIX_NEAR    = 2;

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_BITS-1:0]  s_axis_tdata  = '0;   // [15:0] center, [31:16] neighbor
    logic                     s_axis_tlast  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_axis_tdata;         // [37:0] distance_sum, [39:38] zero
    logic                     m_axis_tlast;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr         = '0;
    logic [APB_DATA_BITS-1:0] pwdata        = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int errors;
    int pending;
    int columns_in;
    int rows_in;
    int sums_out;
    int ready_wait = 0;
    int ready_calm = 0;
    int send_calm  = 0;
    int sent       = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    sq_diff_horizontal_box_sum_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    box_sum_checker #(
        .OFFSET_ADDR (ADDR_OFFSET_X),
        .RADIUS_ADDR (ADDR_BOX_RADIUS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending),
        .columns_in    (columns_in),
        .rows_in       (rows_in),
        .sums_out      (sums_out)
    );

    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic int next_send_gap();
        int r;
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
            send_calm = $urandom_range(30, 120);
        if (r < 70)
            return 0;
        return pick_gap();
    endfunction

    always @(negedge clk)
    begin
        int r;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (ready_wait > 0)
        begin
            ready_wait--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (ready_calm > 0)
                ready_calm--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    ready_calm = $urandom_range(40, 200);
                else if (r < 18)
                    ready_wait = pick_gap();
            end
        end
    end

    task automatic send_column(input logic [15:0] c, input logic [15:0] nb, input logic is_last);
        int gap;
        gap = next_send_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tlast  <= 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nb, c};
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic pick_pair(input int mix, output logic [15:0] c, output logic [15:0] nb);
        c  = 16'($urandom);
        nb = 16'($urandom);
        if (mix == MIX_EXTREME)
        begin
            c  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            nb = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        else if (mix == MIX_NEAR)
            nb = c + 16'($urandom_range(0, 16)) - 16'd8;
    endtask

    task automatic send_columns(input int count, input int mix, input logic close_row);
        logic [15:0] c;
        logic [15:0] nb;
        for (int i = 0; i < count; i++)
        begin
            pick_pair(mix, c, nb);
            send_column(c, nb, close_row && (i == count - 1));
        end
    endtask

    // hold the sender until every expected sum is out and the flush has settled
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (FLUSH_WAIT) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
                              input logic [APB_DATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [OFFCFG_BITS-1:0] off,
                              input logic [RADCFG_BITS-1:0] rad);
        logic [APB_DATA_BITS-1:0] word;
        wait_idle();
        word = $urandom;
        word[OFFCFG_BITS-1:0] = off;
        apb_access(1'b1, ADDR_OFFSET_X, word);
        word = $urandom;
        word[RADCFG_BITS-1:0] = rad;
        apb_access(1'b1, ADDR_BOX_RADIUS, word);
        apb_access(1'b0, ADDR_OFFSET_X, $urandom);
        apb_access(1'b0, ADDR_BOX_RADIUS, $urandom);
    endtask

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int width;
        int mix;
        int r;
        logic [OFFCFG_BITS-1:0] off;
        logic [RADCFG_BITS-1:0] rad;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, ADDR_OFFSET_X, '0);
        apb_access(1'b0, ADDR_BOX_RADIUS, '0);

        // a one-column row and a two-column row at reset settings, largest difference first
        send_column(16'h0000, 16'hFFFF, 1'b1);
        send_column(16'hFFFF, 16'h0000, 1'b0);
        send_column(16'hFFFF, 16'hFFFF, 1'b1);

        // rows narrower than the offset, the first also narrower than the window
        set_config(5'd8, 4'd8);
        send_column(16'hFFFF, 16'h0000, 1'b0);
        send_column(16'h0000, 16'hFFFF, 1'b0);
        send_column(16'hAAAA, 16'h5555, 1'b1);

        set_config(5'h18, 4'd0);
        send_column(16'h5555, 16'hAAAA, 1'b0);
        send_column(16'h0001, 16'h0000, 1'b0);
        send_column(16'h0000, 16'h0001, 1'b0);
        send_column(16'h8000, 16'h7FFF, 1'b1);

        // out-of-range settings clamp
        set_config(5'h0F, 4'd15);
        send_columns(4, MIX_RANDOM, 1'b1);
        set_config(5'h10, 4'd9);
        send_columns(3, MIX_EXTREME, 1'b1);

        // setting changed mid-row applies from the next row
        set_config(5'd3, 4'd2);
        send_columns(3, MIX_RANDOM, 1'b0);
        set_config(5'h1E, 4'd5);
        send_columns(3, MIX_NEAR, 1'b1);
        send_columns(2, MIX_RANDOM, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                off = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(0, 16) - 8) : 5'($urandom);
                rad = ($urandom_range(0, 6) != 0) ? 4'($urandom_range(0, 8))
                                                  : 4'($urandom_range(9, 15));
                set_config(off, rad);
            end
            r = $urandom_range(0, 99);
            width = (r < 70) ? $urandom_range(1, 12) :
                    (r < 96) ? $urandom_range(13, 40) : $urandom_range(60, 70);
            mix = $urandom_range(MIX_RANDOM, MIX_NEAR);
            if (width > 1 && $urandom_range(0, 9) == 0)
            begin
                send_columns(width / 2, mix, 1'b0);
                if ($urandom_range(0, 1) == 0)
                    set_config(5'($urandom_range(0, 16) - 8), 4'($urandom_range(0, 8)));
                else
                    wait_idle();
                send_columns(width - width / 2, mix, 1'b1);
            end
            else
                send_columns(width, mix, 1'b1);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (pending != 0)
            $display("%0t: %0d expected sums never arrived", $time, pending);
        $display("Streamed %0d columns in %0d rows, checked %0d box sums", columns_in,
                 rows_in, sums_out);
        $display("across offsets -8..8 and radii 0..8, clamped settings and a mid-row change.");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sq_diff_horizontal_box_sum_top.f */
rtl/sqdbs_pkg.sv
rtl/sqdbs_cell.sv
rtl/sqdbs_sq3.sv
rtl/sqdbs_box.sv
rtl/sq_diff_horizontal_box_sum_top.sv
tb/box_sum_checker.sv
tb/testbench.sv
